// ===== src/osprc_pkg.sv =====
package osprc_pkg;

	localparam int DELAY_W = 63;
	localparam int FREQ_W  = 32;
	localparam int CNT_W   = 16;
	localparam int NS_W    = 30;

	localparam logic [NS_W-1:0]   NS_PER_SEC  = 30'd1000000000;
	localparam logic [CNT_W-1:0]  COUNTER_MAX = 16'hFFFF;
	localparam logic [FREQ_W-1:0] FREQ_RESET  = 32'd48000000;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_CLOCK_FAST = 2'd1,
		ST_DELAY_LONG = 2'd2,
		ST_DIV_ZERO   = 2'd3
	} status_t;

	// sideband carried along each divider chain
	typedef struct packed {
		logic [DELAY_W-1:0] delay;
		logic [FREQ_W-1:0]  freq;
		status_t            st;
	} side_a_t;

	typedef struct packed {
		logic [DELAY_W-1:0] delay;
		logic [FREQ_W-1:0]  freq;
		status_t            st;
		logic               zero_ticks;
	} side_b_t;

	typedef struct packed {
		logic [DELAY_W-1:0] delay;
		status_t            st;
		logic               zero_ticks;
		logic [CNT_W-1:0]   psc;
	} side_c_t;

	typedef struct packed {
		status_t          st;
		logic             zero_ticks;
		logic [CNT_W-1:0] psc;
	} side_e_t;

endpackage

// ===== src/osprc_if.sv =====
interface osprc_delay_if;
	logic                             valid;
	logic                             ready;
	logic [osprc_pkg::DELAY_W-1:0]    delay_ns;
	modport source(output valid, output delay_ns, input ready);
	modport sink(input valid, input delay_ns, output ready);
endinterface

interface osprc_timer_if;
	logic                           valid;
	logic                           ready;
	logic [osprc_pkg::CNT_W-1:0]    prescaler;
	logic [osprc_pkg::CNT_W-1:0]    reload;
	logic [1:0]                     status;
	modport source(output valid, output prescaler, output reload, output status, input ready);
	modport sink(input valid, input prescaler, input reload, input status, output ready);
endinterface

// ===== src/osprc_cell.sv =====
// One restoring-division step: resolves quotient bit K.
module osprc_cell #(
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int QB = 32,
	parameter int SW = 8,
	parameter int K  = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic [NW-1:0] rem_i,
	input  logic [DW-1:0] d_i,
	input  logic [QB-1:0] q_i,
	input  logic [SW-1:0] side_i,
	output logic          v_o,
	output logic [NW-1:0] rem_o,
	output logic [DW-1:0] d_o,
	output logic [QB-1:0] q_o,
	output logic [SW-1:0] side_o
);
	localparam int CW = (NW > DW + K) ? NW : DW + K;

	logic [CW-1:0] rem_w;
	logic [CW-1:0] sh_w;
	logic          ge;
	logic          v_q;
	logic [NW-1:0] rem_q;
	logic [DW-1:0] d_q;
	logic [QB-1:0] q_q;
	logic [SW-1:0] side_q;

	assign rem_w = CW'(rem_i);
	assign sh_w  = CW'(d_i) << K;
	assign ge    = rem_w >= sh_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? NW'(rem_w - sh_w) : rem_i;
			d_q    <= d_i;
			q_q    <= q_i | (QB'(ge) << K);
			side_q <= side_i;
		end
	end

	assign v_o    = v_q;
	assign rem_o  = rem_q;
	assign d_o    = d_q;
	assign q_o    = q_q;
	assign side_o = side_q;
endmodule

// ===== src/osprc_chain.sv =====
// Row of QB division cells, most significant quotient bit first.
module osprc_chain #(
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int QB = 32,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic [NW-1:0] num_i,
	input  logic [DW-1:0] d_i,
	input  logic [SW-1:0] side_i,
	output logic          v_o,
	output logic [QB-1:0] q_o,
	output logic [SW-1:0] side_o
);
	logic          v_a    [QB+1];
	logic [NW-1:0] rem_a  [QB+1];
	logic [DW-1:0] d_a    [QB+1];
	logic [QB-1:0] q_a    [QB+1];
	logic [SW-1:0] side_a [QB+1];

	assign v_a[0]    = v_i;
	assign rem_a[0]  = num_i;
	assign d_a[0]    = d_i;
	assign q_a[0]    = '0;
	assign side_a[0] = side_i;

	for (genvar i = 0; i < QB; i++) begin : g_cell
		osprc_cell #(
			.NW(NW), .DW(DW), .QB(QB), .SW(SW), .K(QB - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (v_a[i]),
			.rem_i  (rem_a[i]),
			.d_i    (d_a[i]),
			.q_i    (q_a[i]),
			.side_i (side_a[i]),
			.v_o    (v_a[i+1]),
			.rem_o  (rem_a[i+1]),
			.d_o    (d_a[i+1]),
			.q_o    (q_a[i+1]),
			.side_o (side_a[i+1])
		);
	end

	assign v_o    = v_a[QB];
	assign q_o    = q_a[QB];
	assign side_o = side_a[QB];
endmodule

// ===== src/one_shot_prescaler_reload_calc_top.sv =====
// One-shot timer prescaler / auto-reload calculator.
// req carries delay_ns; rsp returns prescaler, reload and status, one item
// per request, in order. Both are valid/ready channels.
// The clock frequency register sits at APB byte address 0 (reset 48 MHz);
// write it only while no item is in flight.
// Datapath: five chains of restoring-division cells, one quotient bit per
// cell per cycle while rsp does not stall (30 + 17 + 32 + 30 + 17 cells), one
// junction register after the first chain and the output register. All cells
// advance together, so a new item is taken every cycle unless rsp stalls:
// sustained throughput one item per cycle while rsp is not stalled.
// When rsp stalls with a result held, the whole row freezes and req.ready
// drops; it returns as soon as the result is taken.
// Reset empties the pipeline (all valid bits cleared) and restores the
// frequency register.
module one_shot_prescaler_reload_calc_top (
	input  logic                 clk,
	input  logic                 arst_n,
	osprc_delay_if.sink          req,
	osprc_timer_if.source        rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	localparam int DW_B = osprc_pkg::NS_W + osprc_pkg::CNT_W;
	localparam int QB_S = osprc_pkg::CNT_W + 1;

	logic [osprc_pkg::FREQ_W-1:0] freq_q;
	logic                         en;
	logic                         wr;

	// chain A: tick_ns = 1e9 / freq
	osprc_pkg::side_a_t           a_side_in, a_side;
	logic                         a_v;
	logic [osprc_pkg::NS_W-1:0]   a_q;
	logic [$bits(osprc_pkg::side_a_t)-1:0] a_side_w;

	// junction after A
	logic                         j1_v_s1;
	logic [DW_B-1:0]              j1_d_s1;
	osprc_pkg::side_b_t           j1_side_s1;
	osprc_pkg::status_t           st1;

	// chain B: psc = delay / (tick_ns * 65535)
	logic                         b_v;
	logic [QB_S-1:0]              b_q;
	osprc_pkg::side_b_t           b_side;
	logic [$bits(osprc_pkg::side_b_t)-1:0] b_side_w;

	// chain C: div_clk = freq / (psc + 1)
	osprc_pkg::side_c_t           c_side_in, c_side;
	osprc_pkg::status_t           st2;
	logic                         c_v;
	logic [osprc_pkg::FREQ_W-1:0] c_q;
	logic [$bits(osprc_pkg::side_c_t)-1:0] c_side_w;

	// chain D: div_tick_ns = 1e9 / div_clk
	osprc_pkg::side_c_t           d_side_in, d_side;
	osprc_pkg::status_t           st3;
	logic                         d_v;
	logic [osprc_pkg::NS_W-1:0]   d_q;
	logic [$bits(osprc_pkg::side_c_t)-1:0] d_side_w;

	// chain E: reload = delay / div_tick_ns, top bit flags saturation
	osprc_pkg::side_e_t           e_side_in, e_side;
	logic                         e_v;
	logic [QB_S-1:0]              e_q;
	logic [$bits(osprc_pkg::side_e_t)-1:0] e_side_w;

	logic                         out_v_q;
	logic [osprc_pkg::CNT_W-1:0]  psc_q;
	logic [osprc_pkg::CNT_W-1:0]  rld_q;
	osprc_pkg::status_t           st_q;

	// config port
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? freq_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= osprc_pkg::FREQ_RESET;
		end else if (wr) begin
			freq_q <= pwdata;
		end
	end

	assign en        = !out_v_q || rsp.ready;
	assign req.ready = en;

	// chain A
	assign a_side_in.delay = req.delay_ns;
	assign a_side_in.freq  = freq_q;
	assign a_side_in.st    = (freq_q == '0) ? osprc_pkg::ST_DIV_ZERO : osprc_pkg::ST_OK;

	osprc_chain #(
		.NW(osprc_pkg::NS_W), .DW(osprc_pkg::FREQ_W), .QB(osprc_pkg::NS_W),
		.SW($bits(osprc_pkg::side_a_t))
	) u_chain_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_i(req.valid), .num_i(osprc_pkg::NS_PER_SEC), .d_i(freq_q),
		.side_i(a_side_in), .v_o(a_v), .q_o(a_q), .side_o(a_side_w)
	);
	assign a_side = a_side_w;

	assign st1 = (a_side.st != osprc_pkg::ST_OK) ? a_side.st :
		(a_q == '0) ? osprc_pkg::ST_CLOCK_FAST : osprc_pkg::ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j1_v_s1 <= 1'b0;
		end else if (en) begin
			j1_v_s1 <= a_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			j1_d_s1                <= {a_q, osprc_pkg::CNT_W'(0)} - DW_B'(a_q);
			j1_side_s1.delay       <= a_side.delay;
			j1_side_s1.freq        <= a_side.freq;
			j1_side_s1.st          <= st1;
			j1_side_s1.zero_ticks  <= a_side.delay < osprc_pkg::DELAY_W'(a_q);
		end
	end

	// chain B
	osprc_chain #(
		.NW(osprc_pkg::DELAY_W), .DW(DW_B), .QB(QB_S),
		.SW($bits(osprc_pkg::side_b_t))
	) u_chain_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_i(j1_v_s1), .num_i(j1_side_s1.delay), .d_i(j1_d_s1),
		.side_i(j1_side_s1), .v_o(b_v), .q_o(b_q), .side_o(b_side_w)
	);
	assign b_side = b_side_w;

	assign st2 = (b_side.st != osprc_pkg::ST_OK) ? b_side.st :
		b_q[QB_S-1] ? osprc_pkg::ST_DELAY_LONG : osprc_pkg::ST_OK;

	assign c_side_in.delay      = b_side.delay;
	assign c_side_in.st         = st2;
	assign c_side_in.zero_ticks = b_side.zero_ticks;
	assign c_side_in.psc        = b_q[osprc_pkg::CNT_W-1:0];

	// chain C
	osprc_chain #(
		.NW(osprc_pkg::FREQ_W), .DW(QB_S), .QB(osprc_pkg::FREQ_W),
		.SW($bits(osprc_pkg::side_c_t))
	) u_chain_c (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_i(b_v), .num_i(b_side.freq),
		.d_i(QB_S'(b_q[osprc_pkg::CNT_W-1:0]) + QB_S'(1)),
		.side_i(c_side_in), .v_o(c_v), .q_o(c_q), .side_o(c_side_w)
	);
	assign c_side = c_side_w;

	assign st3 = (c_side.st != osprc_pkg::ST_OK) ? c_side.st :
		(!c_side.zero_ticks && c_q == '0) ? osprc_pkg::ST_DIV_ZERO : osprc_pkg::ST_OK;

	assign d_side_in.delay      = c_side.delay;
	assign d_side_in.st         = st3;
	assign d_side_in.zero_ticks = c_side.zero_ticks;
	assign d_side_in.psc        = c_side.psc;

	// chain D
	osprc_chain #(
		.NW(osprc_pkg::NS_W), .DW(osprc_pkg::FREQ_W), .QB(osprc_pkg::NS_W),
		.SW($bits(osprc_pkg::side_c_t))
	) u_chain_d (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_i(c_v), .num_i(osprc_pkg::NS_PER_SEC), .d_i(c_q),
		.side_i(d_side_in), .v_o(d_v), .q_o(d_q), .side_o(d_side_w)
	);
	assign d_side = d_side_w;

	assign e_side_in.st         = d_side.st;
	assign e_side_in.zero_ticks = d_side.zero_ticks;
	assign e_side_in.psc        = d_side.psc;

	// chain E
	osprc_chain #(
		.NW(osprc_pkg::DELAY_W), .DW(osprc_pkg::NS_W), .QB(QB_S),
		.SW($bits(osprc_pkg::side_e_t))
	) u_chain_e (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_i(d_v), .num_i(d_side.delay), .d_i(d_q),
		.side_i(e_side_in), .v_o(e_v), .q_o(e_q), .side_o(e_side_w)
	);
	assign e_side = e_side_w;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= e_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= e_side.st;
			if (e_side.st != osprc_pkg::ST_OK) begin
				psc_q <= '0;
				rld_q <= '0;
			end else if (e_side.zero_ticks) begin
				psc_q <= '0;
				rld_q <= osprc_pkg::CNT_W'(1);
			end else begin
				psc_q <= e_side.psc;
				rld_q <= e_q[QB_S-1] ? osprc_pkg::COUNTER_MAX : e_q[osprc_pkg::CNT_W-1:0];
			end
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.prescaler = psc_q;
	assign rsp.reload    = rld_q;
	assign rsp.status    = st_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != osprc_pkg::ST_OK |-> rsp.prescaler == '0 && rsp.reload == '0)
		else $error("error result with nonzero fields");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!rsp.valid || rsp.ready))
		else $error("input ready does not follow output stall");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == 1'b0 |=> freq_q == $past(pwdata))
		else $error("frequency register write lost");
endmodule
